### src/nnps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nnps_pkg;

  // Fixed field widths
  localparam int PIX_W    = 16;
  localparam int COORD_W  = 12;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 3;

  // Stream widths: out tdata = pixel_out, out_col, out_row (40 bits, 5 bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_ENABLE   = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 13'd800;
  localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 13'd600;
  localparam logic [CFG_W-1:0] RST_TARGET_WIDTH  = 13'd144;
  localparam logic [CFG_W-1:0] RST_TARGET_HEIGHT = 13'd256;

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               row_last;
    logic               frame_last;
  } nnps_res_t;

endpackage

`default_nettype wire

### src/nnps_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers and clamped frame sizes
module nnps_cfg #(
  parameter int MAX_DIM = 4096,
  parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wen,
  input  wire logic [nnps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nnps_pkg::CFG_W-1:0]     cfg_wdata,
  output logic      [DIM_W-1:0]              src_w,
  output logic      [DIM_W-1:0]              src_h,
  output logic      [DIM_W-1:0]              dst_w,
  output logic      [DIM_W-1:0]              dst_h,
  output logic                               swap_en
);
  import nnps_pkg::*;

  localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);
  localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1);

  logic [CFG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic             swap_r;
  logic [EXT_W-1:0] sw_raw, sh_raw, dw_raw, dh_raw;
  logic [EXT_W-1:0] sw_c, sh_c, dw_c, dh_c;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SOURCE_WIDTH;
      src_h_r <= RST_SOURCE_HEIGHT;
      dst_w_r <= RST_TARGET_WIDTH;
      dst_h_r <= RST_TARGET_HEIGHT;
      swap_r  <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  src_w_r <= cfg_wdata;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_wdata;
        REG_TARGET_WIDTH:  dst_w_r <= cfg_wdata;
        REG_TARGET_HEIGHT: dst_h_r <= cfg_wdata;
        REG_SWAP_ENABLE:   swap_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Zero reads as one; source clamps to MAX_DIM, target clamps to source
  always_comb begin
    sw_raw = EXT_W'(src_w_r);
    sh_raw = EXT_W'(src_h_r);
    dw_raw = EXT_W'(dst_w_r);
    dh_raw = EXT_W'(dst_h_r);

    if (sw_raw == '0)          sw_c = ONE_EXT;
    else if (sw_raw > MAX_EXT) sw_c = MAX_EXT;
    else                       sw_c = sw_raw;

    if (sh_raw == '0)          sh_c = ONE_EXT;
    else if (sh_raw > MAX_EXT) sh_c = MAX_EXT;
    else                       sh_c = sh_raw;

    if (dw_raw == '0)          dw_c = ONE_EXT;
    else if (dw_raw > sw_c)    dw_c = sw_c;
    else                       dw_c = dw_raw;

    if (dh_raw == '0)          dh_c = ONE_EXT;
    else if (dh_raw > sh_c)    dh_c = sh_c;
    else                       dh_c = dh_raw;
  end

  assign src_w   = DIM_W'(sw_c);
  assign src_h   = DIM_W'(sh_c);
  assign dst_w   = DIM_W'(dw_c);
  assign dst_h   = DIM_W'(dh_c);
  assign swap_en = swap_r;

endmodule

`default_nettype wire

### src/nnps_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Source/destination counters, position accumulators and keep decision
module nnps_step #(
  parameter int MAX_DIM = 4096,
  parameter int DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [nnps_pkg::PIX_W-1:0] pixel_in,
  input  wire logic                       frame_start,
  input  wire logic [DIM_W-1:0]           src_w,
  input  wire logic [DIM_W-1:0]           src_h,
  input  wire logic [DIM_W-1:0]           dst_w,
  input  wire logic [DIM_W-1:0]           dst_h,
  input  wire logic                       swap_en,
  output logic                            keep,
  output nnps_pkg::nnps_res_t             res
);
  import nnps_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int ACC_W = 2 * CNT_W;

  logic [CNT_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;
  logic [DIM_W-1:0] dst_col_r, dst_col_nxt, dst_row_r, dst_row_nxt;
  logic [ACC_W-1:0] col_pos_r, col_pos_nxt, col_tgt_r, col_tgt_nxt;
  logic [ACC_W-1:0] row_pos_r, row_pos_nxt, row_tgt_r, row_tgt_nxt;

  // Effective state after an optional frame_start clear
  logic [CNT_W-1:0] src_col, src_row;
  logic [DIM_W-1:0] dst_col, dst_row;
  logic [ACC_W-1:0] col_pos, col_tgt, row_pos, row_tgt;

  logic [DIM_W:0] dst_col_inc, dst_row_inc, src_col_inc, src_row_inc;
  logic           col_keep, row_keep, rl, fl;
  logic           row_end, frame_end;

  always_comb begin
    src_col = frame_start ? '0 : src_col_r;
    src_row = frame_start ? '0 : src_row_r;
    dst_col = frame_start ? '0 : dst_col_r;
    dst_row = frame_start ? '0 : dst_row_r;
    col_pos = frame_start ? '0 : col_pos_r;
    col_tgt = frame_start ? '0 : col_tgt_r;
    row_pos = frame_start ? '0 : row_pos_r;
    row_tgt = frame_start ? '0 : row_tgt_r;
  end

  // Keep test: x < w and x*W < (c+1)*w, same for rows
  always_comb begin
    dst_col_inc = {1'b0, dst_col} + (DIM_W+1)'(1);
    dst_row_inc = {1'b0, dst_row} + (DIM_W+1)'(1);
    src_col_inc = (DIM_W+1)'(src_col) + (DIM_W+1)'(1);
    src_row_inc = (DIM_W+1)'(src_row) + (DIM_W+1)'(1);

    col_keep = (dst_col < dst_w) &&
               ({1'b0, col_tgt} < ({1'b0, col_pos} + (ACC_W+1)'(dst_w)));
    row_keep = (dst_row < dst_h) &&
               ({1'b0, row_tgt} < ({1'b0, row_pos} + (ACC_W+1)'(dst_h)));
    rl = (dst_col_inc == {1'b0, dst_w});
    fl = rl && (dst_row_inc == {1'b0, dst_h});
    row_end   = (src_col_inc >= {1'b0, src_w});
    frame_end = (src_row_inc >= {1'b0, src_h});
  end

  // Result item
  always_comb begin
    keep           = col_keep && row_keep;
    res.pixel      = swap_en ? {pixel_in[7:0], pixel_in[15:8]} : pixel_in;
    res.col        = COORD_W'(dst_col);
    res.row        = COORD_W'(dst_row);
    res.row_last   = rl;
    res.frame_last = fl;
  end

  // Next state
  always_comb begin
    src_col_nxt = src_col;
    src_row_nxt = src_row;
    dst_col_nxt = dst_col;
    dst_row_nxt = dst_row;
    col_pos_nxt = col_pos;
    col_tgt_nxt = col_tgt;
    row_pos_nxt = row_pos;
    row_tgt_nxt = row_tgt;

    if (col_keep) begin
      if (dst_col_inc < {1'b0, dst_w}) col_tgt_nxt = col_tgt + ACC_W'(src_w);
      dst_col_nxt = DIM_W'(dst_col_inc);
    end

    if (row_end) begin
      src_col_nxt = '0;
      dst_col_nxt = '0;
      col_pos_nxt = '0;
      col_tgt_nxt = '0;
      if (row_keep) begin
        if (dst_row_inc < {1'b0, dst_h}) row_tgt_nxt = row_tgt + ACC_W'(src_h);
        dst_row_nxt = DIM_W'(dst_row_inc);
      end
      if (frame_end) begin
        src_row_nxt = '0;
        dst_row_nxt = '0;
        row_pos_nxt = '0;
        row_tgt_nxt = '0;
      end else begin
        src_row_nxt = CNT_W'(src_row_inc);
        row_pos_nxt = row_pos + ACC_W'(dst_h);
      end
    end else begin
      src_col_nxt = CNT_W'(src_col_inc);
      col_pos_nxt = col_pos + ACC_W'(dst_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      dst_col_r <= '0;
      dst_row_r <= '0;
      col_pos_r <= '0;
      col_tgt_r <= '0;
      row_pos_r <= '0;
      row_tgt_r <= '0;
    end else if (accept) begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      dst_col_r <= dst_col_nxt;
      dst_row_r <= dst_row_nxt;
      col_pos_r <= col_pos_nxt;
      col_tgt_r <= col_tgt_nxt;
      row_pos_r <= row_pos_nxt;
      row_tgt_r <= row_tgt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/nearest_neighbor_pixel_scaler_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake           Payload
// in_      in   tvalid/tready       tdata: pixel_in; tuser: frame_start
// out_     out  tvalid/tready       tdata: pixel_out, out_col, out_row;
//                                   tlast: row_last; tuser: frame_last
// cfg_     in   wen (no stall)      index, wdata
//
// One source pixel per clock unless out_ stalls; a kept pixel appears on out_ in
// the next cycle, held in the output register. Counters and accumulators
// update in the accept cycle, so the rate is set by one add and compare per axis.
// in_tready stays high while the output register is empty or being drained.
// Reset (synchronous, active low) clears counters and restores register defaults.
module nearest_neighbor_pixel_scaler_core #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tdata [15:0] pixel_in
  input  wire logic [nnps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser [0] frame_start
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata [15:0] pixel_out, [27:16] out_col, [39:28] out_row
  output logic      [nnps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                   out_tlast,
  // tuser [0] frame_last
  output logic                                   out_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wen,
  input  wire logic [nnps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nnps_pkg::CFG_W-1:0]        cfg_wdata
);
  import nnps_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
  logic             swap_en;
  logic             accept, keep;
  nnps_res_t        res;
  nnps_res_t        out_r;
  logic             out_valid_r, out_valid_nxt;

  nnps_cfg #(.MAX_DIM(MAX_DIM), .DIM_W(DIM_W)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src_w     (src_w),
    .src_h     (src_h),
    .dst_w     (dst_w),
    .dst_h     (dst_h),
    .swap_en   (swap_en)
  );

  nnps_step #(.MAX_DIM(MAX_DIM), .DIM_W(DIM_W)) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel_in    (in_tdata[PIX_W-1:0]),
    .frame_start (in_tuser),
    .src_w       (src_w),
    .src_h       (src_h),
    .dst_w       (dst_w),
    .dst_h       (dst_h),
    .swap_en     (swap_en),
    .keep        (keep),
    .res         (res)
  );

  // Handshake: take a new item whenever the output register is free next cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)          out_valid_nxt = keep;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (accept && keep) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.row, out_r.col, out_r.pixel};
  assign out_tlast  = out_r.row_last;
  assign out_tuser  = out_r.frame_last;

endmodule

`default_nettype wire

### tb/sv/tb_nearest_neighbor_pixel_scaler_core.sv
`timescale 1ns / 1ps

module tb_nearest_neighbor_pixel_scaler_core;
  import nnps_pkg::*;

  localparam int MAX_SIZE       = 4096;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 500;
  localparam int LARGE_ITEMS    = 40;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int TIME_LIMIT_NS  = 5_000_000;

  // Indexes past the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_WAIT_IDLE} stim_kind_t;
  typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct {
    stim_kind_t           kind;
    logic [PIX_W-1:0]     pixel;
    logic                 frame_start;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } stim_op_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  nearest_neighbor_pixel_scaler_core #(
    .MAX_DIM(MAX_SIZE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  stim_op_t   pending_q[$];
  nnps_res_t  kept_q[$];
  logic [CFG_W-1:0] plan_cfg [0:4];

  // Scaler copy: registers
  logic [CFG_W-1:0] src_w_reg = RST_SOURCE_WIDTH;
  logic [CFG_W-1:0] src_h_reg = RST_SOURCE_HEIGHT;
  logic [CFG_W-1:0] dst_w_reg = RST_TARGET_WIDTH;
  logic [CFG_W-1:0] dst_h_reg = RST_TARGET_HEIGHT;
  logic             swap_reg  = 1'b1;

  // Scaler copy: counters and accumulators
  logic [11:0] src_col = '0;
  logic [11:0] src_row = '0;
  logic [12:0] dst_col = '0;
  logic [12:0] dst_row = '0;
  logic [23:0] col_pos_acc = '0;
  logic [23:0] col_tgt_acc = '0;
  logic [23:0] row_pos_acc = '0;
  logic [23:0] row_tgt_acc = '0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  logic in_taken     = 1'b0;

  // Sender burst state
  int gap_left   = 0;
  int burst_left = 0;

  // Receiver stall state
  rx_mode_t rx_mode   = RX_ALWAYS;
  int mode_left       = 0;
  int rx_cycle        = 0;
  int hold_left       = 0;
  logic holdoff_done  = 1'b0;

  // Size registers: zero reads as one, anything above the limit saturates
  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CFG_W'($urandom_range(4097, 8191));
      2:       return CFG_W'($urandom_range(13, 64));
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic clear_row_counts();
    src_col = '0;
    dst_col = '0;
    col_pos_acc = '0;
    col_tgt_acc = '0;
  endtask

  task automatic clear_frame_counts();
    clear_row_counts();
    src_row = '0;
    dst_row = '0;
    row_pos_acc = '0;
    row_tgt_acc = '0;
  endtask

  // One source pixel: decide whether it lands in the destination grid
  task automatic downscale_step(input logic [PIX_W-1:0] pix, input logic fs);
    int sw, sh, dw, dh;
    logic col_keep, row_keep, rl;
    nnps_res_t res;
    sw = clamp_size(src_w_reg, MAX_SIZE);
    sh = clamp_size(src_h_reg, MAX_SIZE);
    dw = clamp_size(dst_w_reg, sw);
    dh = clamp_size(dst_h_reg, sh);
    if (fs) clear_frame_counts();

    // target acc is x*W, position acc is c*w; keep while x*W < (c+1)*w
    col_keep = (dst_col < dw) && (col_tgt_acc < col_pos_acc + dw);
    row_keep = (dst_row < dh) && (row_tgt_acc < row_pos_acc + dh);

    if (col_keep && row_keep) begin
      rl = (dst_col + 1 == dw);
      res.pixel      = swap_reg ? {pix[7:0], pix[15:8]} : pix;
      res.col        = dst_col[COORD_W-1:0];
      res.row        = dst_row[COORD_W-1:0];
      res.row_last   = rl;
      res.frame_last = rl && (dst_row + 1 == dh);
      kept_q.push_back(res);
    end

    if (col_keep) begin
      if (dst_col + 1 < dw) col_tgt_acc += sw;
      dst_col++;
    end

    // end of source row, possibly end of frame
    if (src_col + 1 >= sw) begin
      clear_row_counts();
      if (row_keep) begin
        if (dst_row + 1 < dh) row_tgt_acc += sh;
        dst_row++;
      end
      if (src_row + 1 >= sh) begin
        clear_frame_counts();
      end else begin
        src_row++;
        row_pos_acc += dh;
      end
    end else begin
      src_col++;
      col_pos_acc += dw;
    end
  endtask

  function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                      input logic [PIX_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    stim_op_t op;
    op = '{kind: OP_PIXEL, pixel: pix, frame_start: fs, index: '0, data: '0};
    pending_q.push_back(op);
  endtask

  task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_op_t op;
    op = '{kind: OP_WRITE, pixel: '0, frame_start: 1'b0, index: idx, data: val};
    pending_q.push_back(op);
    if (idx <= REG_SWAP_ENABLE) plan_cfg[idx] = val;
  endtask

  task automatic push_idle();
    stim_op_t op;
    op = '{kind: OP_WAIT_IDLE, pixel: '0, frame_start: 1'b0, index: '0, data: '0};
    pending_q.push_back(op);
  endtask

  // Sender: items in bursts; register writes and pauses wait for an idle block
  always @(negedge clk) begin : driver
    stim_op_t op;
    logic nxt_valid;
    logic nxt_wen;
    nxt_valid = 1'b0;
    nxt_wen   = 1'b0;
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        nxt_valid = 1'b1;
      end else if (pending_q.size() > 0) begin
        op = pending_q[0];
        case (op.kind)
          OP_PIXEL: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              void'(pending_q.pop_front());
              nxt_valid = 1'b1;
              in_tdata <= op.pixel;
              in_tuser <= op.frame_start;
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(0, 20);
                gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
          end
          default: begin
            if (kept_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              void'(pending_q.pop_front());
              if (op.kind == OP_WRITE) begin
                nxt_wen = 1'b1;
                cfg_index <= op.index;
                cfg_wdata <= op.data;
              end
            end
          end
        endcase
      end
    end
    in_tvalid <= nxt_valid;
    cfg_wen   <= nxt_wen;
  end

  // Receiver: stall modes that change now and then, plus one long hold-off
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      rx_cycle++;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 96);
      end else begin
        mode_left--;
      end
      if (!holdoff_done && results_seen >= 50 && in_tvalid) begin
        hold_left    = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_tready <= 1'b1;
          RX_HALF:     out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_tready <= (rx_cycle % 8 != 0);
        endcase
      end
    end
  end

  // Predict on each accepted item, track register writes, check results
  always @(posedge clk) begin : monitor
    nnps_res_t want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        downscale_step(in_tdata[PIX_W-1:0], in_tuser);
        quiet_cycles <= 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles <= quiet_cycles + 1;
      end

      if (cfg_wen) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  src_w_reg = cfg_wdata;
          REG_SOURCE_HEIGHT: src_h_reg = cfg_wdata;
          REG_TARGET_WIDTH:  dst_w_reg = cfg_wdata;
          REG_TARGET_HEIGHT: dst_h_reg = cfg_wdata;
          REG_SWAP_ENABLE:   swap_reg  = cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        results_seen++;
        if (kept_q.size() == 0) begin
          $display("%0t ns: unexpected item, expected none, got tdata=%h tlast=%b tuser=%b",
                   $time, out_tdata, out_tlast, out_tuser);
          mismatch_count++;
        end else begin
          want = kept_q.pop_front();
          check_field("pixel_out", want.pixel, out_tdata[PIX_W-1:0]);
          check_field("out_col", PIX_W'(want.col), PIX_W'(out_tdata[PIX_W +: COORD_W]));
          check_field("out_row", PIX_W'(want.row),
                      PIX_W'(out_tdata[PIX_W+COORD_W +: COORD_W]));
          check_field("row_last", PIX_W'(want.row_last), PIX_W'(out_tlast));
          check_field("frame_last", PIX_W'(want.frame_last), PIX_W'(out_tuser));
        end
      end
    end
  end

  // Stimulus plan, reset and end of run
  initial begin : run
    int random_pixels;
    int frame_px;
    int nframes;
    int count;
    plan_cfg[REG_SOURCE_WIDTH]  = RST_SOURCE_WIDTH;
    plan_cfg[REG_SOURCE_HEIGHT] = RST_SOURCE_HEIGHT;
    plan_cfg[REG_TARGET_WIDTH]  = RST_TARGET_WIDTH;
    plan_cfg[REG_TARGET_HEIGHT] = RST_TARGET_HEIGHT;
    plan_cfg[REG_SWAP_ENABLE]   = 13'd1;

    // reset settings, pixel extremes, swap on
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h00FF, 1'b0);
    // writes past the register map change nothing
    push_write(REG_UNMAPPED_LO, 13'h1FFF);
    push_write(REG_UNMAPPED_HI, 13'h0001);
    push_pixel(16'hFF00, 1'b1);

    // 4x3 source, target width zero (taken as one), height clamped, no swap
    push_write(REG_SOURCE_WIDTH, 13'd4);
    push_write(REG_SOURCE_HEIGHT, 13'd3);
    push_write(REG_TARGET_WIDTH, 13'd0);
    push_write(REG_TARGET_HEIGHT, 13'h1FFF);
    push_write(REG_SWAP_ENABLE, 13'd0);
    for (int i = 0; i < 12; i++) push_pixel(PIX_W'($urandom), i == 0);

    // width shrinks mid-row: the row ends on the next pixel
    push_write(REG_SOURCE_WIDTH, 13'd8);
    push_write(REG_SOURCE_HEIGHT, 13'd4);
    push_write(REG_TARGET_WIDTH, 13'd3);
    push_write(REG_TARGET_HEIGHT, 13'd2);
    push_write(REG_SWAP_ENABLE, 13'd1);
    for (int i = 0; i < 4; i++) push_pixel(PIX_W'($urandom), i == 0);
    push_write(REG_SOURCE_WIDTH, 13'd2);
    for (int i = 0; i < 3; i++) push_pixel(PIX_W'($urandom), 1'b0);
    // frame_start in mid-frame resyncs
    push_pixel(16'h5AA5, 1'b1);
    push_pixel(16'hA55A, 1'b0);

    // largest sizes: start of one column of 4096 rows, then of one row of 4096 columns
    push_write(REG_SOURCE_WIDTH, 13'd1);
    push_write(REG_SOURCE_HEIGHT, 13'h1FFF);
    push_write(REG_TARGET_WIDTH, 13'd1);
    push_write(REG_TARGET_HEIGHT, 13'd5000);
    for (int i = 0; i < LARGE_ITEMS; i++) push_pixel(PIX_W'($urandom), i == 0);
    push_write(REG_SOURCE_WIDTH, 13'h1FFF);
    push_write(REG_SOURCE_HEIGHT, 13'd0);
    push_write(REG_TARGET_WIDTH, 13'd4096);
    push_write(REG_TARGET_HEIGHT, 13'd1);
    for (int i = 0; i < LARGE_ITEMS; i++) push_pixel(PIX_W'($urandom), i == 0);

    // random settings; mostly whole frames, some loose pixels
    random_pixels = 0;
    while (random_pixels < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) push_idle();
      if ($urandom_range(0, 2) == 0) begin
        push_write(REG_SOURCE_WIDTH, rand_size());
        push_write(REG_SOURCE_HEIGHT, rand_size());
        push_write(REG_TARGET_WIDTH, rand_size());
        push_write(REG_TARGET_HEIGHT, rand_size());
        push_write(REG_SWAP_ENABLE, CFG_W'($urandom));
      end else begin
        if ($urandom_range(0, 1)) push_write(REG_SOURCE_WIDTH, rand_size());
        if ($urandom_range(0, 1)) push_write(REG_SOURCE_HEIGHT, rand_size());
        if ($urandom_range(0, 1)) push_write(REG_TARGET_WIDTH, rand_size());
        if ($urandom_range(0, 1)) push_write(REG_TARGET_HEIGHT, rand_size());
        if ($urandom_range(0, 1)) push_write(REG_SWAP_ENABLE, CFG_W'($urandom_range(0, 1)));
      end
      frame_px = clamp_size(plan_cfg[REG_SOURCE_WIDTH], MAX_SIZE) *
                 clamp_size(plan_cfg[REG_SOURCE_HEIGHT], MAX_SIZE);
      if ($urandom_range(0, 3) != 0 && frame_px <= 300 &&
          random_pixels + frame_px <= RANDOM_ITEMS) begin
        nframes = $urandom_range(1, 3);
        // stay within the item budget
        while (nframes > 1 && random_pixels + nframes * frame_px > RANDOM_ITEMS) nframes--;
        for (int f = 0; f < nframes; f++) begin
          for (int p = 0; p < frame_px; p++) begin
            push_pixel(PIX_W'($urandom), p == 0 && (f == 0 || $urandom_range(0, 1) == 1));
          end
        end
        random_pixels += nframes * frame_px;
      end else begin
        count = $urandom_range(1, 40);
        for (int p = 0; p < count; p++) push_pixel(PIX_W'($urandom), $urandom_range(0, 9) == 0);
        random_pixels += count;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_tvalid || kept_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIME_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

### nearest_neighbor_pixel_scaler_core.f
src/nnps_pkg.sv
src/nnps_cfg.sv
src/nnps_step.sv
src/nearest_neighbor_pixel_scaler_core.sv
tb/sv/tb_nearest_neighbor_pixel_scaler_core.sv
